### hw/rtl/iir_direct_form1_limited_defines.svh
// Assertion macros shared by the filter checker.
// No dependencies; included by iirdf1_chk.sv.
`ifndef IIR_DIRECT_FORM1_LIMITED_DEFINES_SVH
`define IIR_DIRECT_FORM1_LIMITED_DEFINES_SVH

// Checked on every rising edge outside reset.
`define IIRDF1_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked on every rising edge, reset included.
`define IIRDF1_ASSERT_ANY(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### hw/rtl/iirdf1_pkg.sv
// Types and constants of the direct-form-I IIR filter.
// No dependencies; used by every module of the filter.
`default_nettype none

package iirdf1_pkg;

	localparam int DATA_W     = 32;  // Q16.16 samples and outputs
	localparam int COEF_W     = 32;  // Q4.28 coefficients
	localparam int PROD_W     = DATA_W + COEF_W;
	localparam int IDX_W      = 4;
	localparam int FUNC_W     = 2;
	localparam int LIMIT_W    = 31;
	localparam int FRAC_SHIFT = 28;  // Q20.44 -> Q16.16
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 32;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

	// register word index (paddr[2])
	localparam logic REG_OUTPUT_LIMIT = 1'b0;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SAMPLE = 2'd0,
		FUNC_WR_NUM = 2'd1,
		FUNC_WR_DEN = 2'd2
	} func_t;

	typedef struct packed {
		func_t                     func;
		logic signed [DATA_W-1:0]  sample;
		logic [IDX_W-1:0]          coef_index;
		logic signed [COEF_W-1:0]  coef_value;
	} item_t;

endpackage

`default_nettype wire

### hw/rtl/iirdf1_dot.sv
// Dot product of N coefficient/data pairs: parallel multipliers and an adder tree.
// Depends on iirdf1_pkg.
`default_nettype none

module iirdf1_dot #(
	parameter int N     = 10,
	parameter int SUM_W = 68
) (
	input  wire logic signed [iirdf1_pkg::COEF_W-1:0] coef [N],
	input  wire logic signed [iirdf1_pkg::DATA_W-1:0] data [N],
	output logic signed [SUM_W-1:0]                   sum
);

	localparam int LVL = $clog2(N);
	localparam int P   = 1 << LVL;

	logic signed [iirdf1_pkg::PROD_W-1:0] prod [N];
	logic signed [SUM_W-1:0]              node [2*P-1];

	genvar k;
	generate
		for (k = 0; k < P; k++) begin : g_leaf
			if (k < N) begin : g_used
				assign prod[k] = coef[k] * data[k];
				assign node[P-1+k] = SUM_W'(prod[k]);
			end else begin : g_pad
				assign node[P-1+k] = '0;
			end
		end
		for (k = 0; k < P-1; k++) begin : g_tree
			assign node[k] = node[2*k+1] + node[2*k+2];
		end
	endgenerate

	assign sum = node[0];

endmodule

`default_nettype wire

### hw/rtl/iir_direct_form1_limited.sv
// Direct-form-I IIR filter with symmetric output clamp: top level.
// Depends on iirdf1_pkg and iirdf1_dot.
// Path: an accepted sample is held in the input register (s1); its result is
//   then registered in the result register that drives m_tdata.
// Throughput: 1 item per cycle, but a sample waits while a result is held and
//   m_tready is low; the y[n-1] feedback path (denominator multipliers, adder tree, round and clamp) is combinational.
// Reset (arst_n low, asynchronous): histories and coefficients cleared,
//   output_limit = 2^31-1, no item held, no result pending.
`default_nettype none

module iir_direct_form1_limited #(
	parameter int TAPS = 10
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	// input items
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	// [31:0] sample, [35:32] coef_index, [67:36] coef_value, [71:68] zero
	input  wire logic [iirdf1_pkg::S_TDATA_W-1:0]   s_tdata,
	// [1:0] func
	input  wire logic [iirdf1_pkg::FUNC_W-1:0]      s_tuser,
	// results
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	// [31:0] filtered
	output logic [iirdf1_pkg::M_TDATA_W-1:0]        m_tdata,
	// configuration
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [iirdf1_pkg::APB_AW-1:0]      paddr,
	input  wire logic [iirdf1_pkg::APB_DW-1:0]      pwdata,
	output logic [iirdf1_pkg::APB_DW-1:0]           prdata,
	output logic                                    pready
);

	localparam int DATA_W = iirdf1_pkg::DATA_W;
	localparam int COEF_W = iirdf1_pkg::COEF_W;
	localparam int FRAC   = iirdf1_pkg::FRAC_SHIFT;
	// sum widths: N products of at most 2^62 each
	localparam int NUM_W  = iirdf1_pkg::PROD_W + $clog2(TAPS);
	localparam int DEN_W  = iirdf1_pkg::PROD_W + $clog2(TAPS-1);
	localparam int ACC_W  = iirdf1_pkg::PROD_W + $clog2(TAPS) + 2;
	localparam int RND_W  = ACC_W - FRAC;
	// coefficient index compare width, wide enough for any tap number
	localparam int CMP_W  = ($clog2(TAPS) + 1 > iirdf1_pkg::IDX_W) ?
	                        $clog2(TAPS) + 1 : iirdf1_pkg::IDX_W;

	localparam logic signed [ACC_W-1:0] RND_HALF =
		{{(ACC_W-FRAC){1'b0}}, 1'b1, {(FRAC-1){1'b0}}};

	// ---------------------------------------------------------------
	// Configuration port: one register, output_limit, at word 0.
	// ---------------------------------------------------------------
	logic [iirdf1_pkg::LIMIT_W-1:0] limit_q;
	logic                           reg_idx;
	logic                           cfg_wr;

	assign reg_idx = paddr[2];
	assign cfg_wr  = psel && penable && pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= iirdf1_pkg::LIMIT_RESET;
		end else if (cfg_wr && (reg_idx == iirdf1_pkg::REG_OUTPUT_LIMIT)) begin
			limit_q <= pwdata[iirdf1_pkg::LIMIT_W-1:0];
		end
	end

	always_comb begin
		if (reg_idx == iirdf1_pkg::REG_OUTPUT_LIMIT) begin
			prdata = {1'b0, limit_q};
		end else begin
			prdata = '0;
		end
	end

	// ---------------------------------------------------------------
	// Input register (s1). Items flow on whenever the result register
	// can take a result; coefficient writes never wait on it.
	// ---------------------------------------------------------------
	iirdf1_pkg::item_t item_s1;
	logic              v_s1;
	logic              adv_s1;
	logic              do_sample;
	logic              do_wnum;
	logic              do_wden;

	always_comb begin
		adv_s1    = 1'b0;
		do_sample = 1'b0;
		do_wnum   = 1'b0;
		do_wden   = 1'b0;
		if (v_s1) begin
			unique case (item_s1.func)
				iirdf1_pkg::FUNC_SAMPLE: begin
					adv_s1    = !m_tvalid || m_tready;
					do_sample = adv_s1;
				end
				iirdf1_pkg::FUNC_WR_NUM: begin
					adv_s1  = 1'b1;
					do_wnum = 1'b1;
				end
				iirdf1_pkg::FUNC_WR_DEN: begin
					adv_s1  = 1'b1;
					do_wden = 1'b1;
				end
				default: begin
					// unused selector: dropped silently
					adv_s1 = 1'b1;
				end
			endcase
		end
	end

	assign s_tready = !v_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (s_tready) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.func       <= iirdf1_pkg::func_t'(s_tuser);
			item_s1.sample     <= s_tdata[31:0];
			item_s1.coef_index <= s_tdata[35:32];
			item_s1.coef_value <= s_tdata[67:36];
		end
	end

	// ---------------------------------------------------------------
	// Coefficients. b[0..TAPS-1]; a[1..TAPS-1] kept as a_q[0..TAPS-2]
	// since a[0] never enters the sum. Out-of-range indexes match no tap.
	// ---------------------------------------------------------------
	logic signed [COEF_W-1:0] b_q [TAPS];
	logic signed [COEF_W-1:0] a_q [TAPS-1];
	logic [CMP_W-1:0]         idx_ext;

	assign idx_ext = CMP_W'(item_s1.coef_index);

	genvar i;
	generate
		for (i = 0; i < TAPS; i++) begin : g_bcoef
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					b_q[i] <= '0;
				end else if (do_wnum && (idx_ext == CMP_W'(i))) begin
					b_q[i] <= item_s1.coef_value;
				end
			end
		end
		for (i = 0; i < TAPS-1; i++) begin : g_acoef
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					a_q[i] <= '0;
				end else if (do_wden && (idx_ext == CMP_W'(i+1))) begin
					a_q[i] <= item_s1.coef_value;
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------
	// Histories: x_q holds x[n-1]..x[n-TAPS+1], y_q holds y[n-1]..
	// y[n-TAPS+1]. xvec is the history after the new sample is shifted in.
	// ---------------------------------------------------------------
	logic signed [DATA_W-1:0] x_q  [TAPS-1];
	logic signed [DATA_W-1:0] y_q  [TAPS-1];
	logic signed [DATA_W-1:0] xvec [TAPS];
	logic signed [DATA_W-1:0] y_next;

	assign xvec[0] = item_s1.sample;
	generate
		for (i = 1; i < TAPS; i++) begin : g_xvec
			assign xvec[i] = x_q[i-1];
		end
		for (i = 0; i < TAPS-1; i++) begin : g_hist
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					x_q[i] <= '0;
					y_q[i] <= '0;
				end else if (do_sample) begin
					x_q[i] <= xvec[i];
					if (i == 0) begin
						y_q[i] <= y_next;
					end else begin
						y_q[i] <= y_q[(i == 0) ? 0 : i-1];
					end
				end
			end
		end
	endgenerate

	// ---------------------------------------------------------------
	// Datapath: feed-forward and feedback dot products, exact sum,
	// round half up to Q16.16, then clamp to +/- output_limit.
	// ---------------------------------------------------------------
	logic signed [NUM_W-1:0] num_sum;
	logic signed [DEN_W-1:0] den_sum;
	logic signed [ACC_W-1:0] acc;
	logic signed [RND_W-1:0] rnd;
	logic signed [RND_W-1:0] lim_pos;
	logic signed [RND_W-1:0] lim_neg;
	logic signed [RND_W-1:0] clamped;

	iirdf1_dot #(
		.N     (TAPS),
		.SUM_W (NUM_W)
	) u_num (
		.coef (b_q),
		.data (xvec),
		.sum  (num_sum)
	);

	iirdf1_dot #(
		.N     (TAPS-1),
		.SUM_W (DEN_W)
	) u_den (
		.coef (a_q),
		.data (y_q),
		.sum  (den_sum)
	);

	assign acc     = ACC_W'(num_sum) - ACC_W'(den_sum) + RND_HALF;
	assign rnd     = acc[ACC_W-1:FRAC];       // floor shift
	assign lim_pos = RND_W'({1'b0, limit_q});
	assign lim_neg = -lim_pos;

	always_comb begin
		priority if (rnd > lim_pos) begin
			clamped = lim_pos;
		end else if (rnd < lim_neg) begin
			clamped = lim_neg;
		end else begin
			clamped = rnd;
		end
	end

	assign y_next = clamped[DATA_W-1:0];

	// ---------------------------------------------------------------
	// Result register.
	// ---------------------------------------------------------------
	logic                              m_tvalid_q;
	logic [iirdf1_pkg::M_TDATA_W-1:0]  m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (do_sample) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (do_sample) begin
			m_tdata_q <= y_next;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

### hw/rtl/iirdf1_chk.sv
// Port-level checker for the IIR filter, bound to the top level.
// Depends on iirdf1_pkg and iir_direct_form1_limited_defines.svh.
`default_nettype none
`include "iir_direct_form1_limited_defines.svh"

module iirdf1_chk (
	input wire logic                               clk,
	input wire logic                               arst_n,
	input wire logic                               s_tvalid,
	input wire logic                               s_tready,
	input wire logic [iirdf1_pkg::S_TDATA_W-1:0]   s_tdata,
	input wire logic [iirdf1_pkg::FUNC_W-1:0]      s_tuser,
	input wire logic                               m_tvalid,
	input wire logic                               m_tready,
	input wire logic [iirdf1_pkg::M_TDATA_W-1:0]   m_tdata,
	input wire logic                               psel,
	input wire logic                               penable,
	input wire logic                               pwrite,
	input wire logic [iirdf1_pkg::APB_AW-1:0]      paddr,
	input wire logic [iirdf1_pkg::APB_DW-1:0]      pwdata,
	input wire logic [iirdf1_pkg::APB_DW-1:0]      prdata,
	input wire logic                               pready
);

	// no result pending after a reset edge
	`IIRDF1_ASSERT_ANY(a_rst_idle, clk, !arst_n |=> !m_tvalid, "result valid during reset")

	// a stalled result stays and keeps its value
	`IIRDF1_ASSERT_RST(a_hold_valid, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
	`IIRDF1_ASSERT_RST(a_hold_data, clk, arst_n, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

	// input back-pressure only while an accepted item is still held
	`IIRDF1_ASSERT_RST(a_ready_cause, clk, arst_n, !s_tready |-> $past(s_tvalid && s_tready) || $past(!s_tready), "input stalled with nothing held")

	// a new result needs an item accepted earlier or still held in the input register
	`IIRDF1_ASSERT_RST(a_result_cause, clk, arst_n, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2) || $past(!s_tready, 2), "result without an accepted sample")

endmodule

bind iir_direct_form1_limited iirdf1_chk u_iirdf1_chk (.*);

`default_nettype wire
